/* design/dws_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dws_pkg
// Shared widths, register indexes, reset values and payload types of the
// differential drive wheel speed block.
// ----------------------------------------------------------------------------
package dws_pkg;

  // signed width of every speed and rate field
  localparam int SPEED_BITS = 16;

  // configuration register widths
  localparam int HW_BITS  = 10;
  localparam int LIM_BITS = 15;
  localparam int THR_BITS = 12;

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 15;

  localparam logic [CFG_IDX_BITS-1:0] REG_HALF_WHEELBASE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPEED_LIMIT    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_STRAIGHT_THR   = 2'd2;

  localparam logic [HW_BITS-1:0]  HALF_WHEELBASE_RST = 10'd75;
  localparam logic [LIM_BITS-1:0] SPEED_LIMIT_RST    = 15'd1000;
  localparam logic [THR_BITS-1:0] STRAIGHT_THR_RST   = 12'd87;

  // wide values carry speeds in units of 1/1000 mm/s
  localparam int SCALE      = 1000;
  localparam int SCALE_BITS = 10;

  localparam int WIDE_BITS = SPEED_BITS + 11;
  localparam int MAG_BITS  = SPEED_BITS + 10;
  localparam int NUM_BITS  = MAG_BITS + LIM_BITS;
  localparam int QUO_BITS  = LIM_BITS;
  localparam int LIMS_BITS = LIM_BITS + SCALE_BITS;

  typedef struct packed {
    logic signed [SPEED_BITS-1:0] linear_speed;
    logic signed [SPEED_BITS-1:0] angular_rate;
  } cmd_t;

  typedef struct packed {
    logic signed [SPEED_BITS-1:0] left_speed;
    logic signed [SPEED_BITS-1:0] right_speed;
    logic                         speed_limited;
  } wheel_t;

endpackage
`default_nettype wire

/* design/dws_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dws_div
// Pipelined restoring divider, one quotient bit per stage. The caller
// guarantees that the quotient fits in QUO_BITS bits and the divisor is
// nonzero.
// ----------------------------------------------------------------------------
module dws_div (
  input  wire logic                          clk,
  input  wire logic                          run,
  input  wire logic [dws_pkg::NUM_BITS-1:0]  num,
  input  wire logic [dws_pkg::MAG_BITS-1:0]  den,
  output logic      [dws_pkg::QUO_BITS-1:0]  quo
);
  import dws_pkg::*;

  logic [NUM_BITS-1:0] rem [QUO_BITS-1];
  logic [MAG_BITS-1:0] dsr [QUO_BITS-1];
  logic [QUO_BITS-1:0] qt  [QUO_BITS];

  for (genvar j = 0; j < QUO_BITS; j++) begin : g_stage
    localparam int SH = QUO_BITS - 1 - j;
    localparam logic [QUO_BITS-1:0] QBIT = QUO_BITS'(1) << SH;

    logic [NUM_BITS-1:0] rem_in;
    logic [MAG_BITS-1:0] dsr_in;
    logic [QUO_BITS-1:0] q_in;
    logic [NUM_BITS-1:0] trial;
    logic                fits;

    if (j == 0) begin : g_first
      assign rem_in = num;
      assign dsr_in = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem[j-1];
      assign dsr_in = dsr[j-1];
      assign q_in   = qt[j-1];
    end

    // divisor aligned to this stage's quotient bit
    assign trial = NUM_BITS'(dsr_in) << SH;
    assign fits  = rem_in >= trial;

    always_ff @(posedge clk) begin
      if (run) begin
        qt[j] <= fits ? (q_in | QBIT) : q_in;
      end
    end

    if (j < QUO_BITS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (run) begin
          rem[j] <= fits ? rem_in - trial : rem_in;
          dsr[j] <= dsr_in;
        end
      end
    end
  end

  assign quo = qt[QUO_BITS-1];

endmodule
`default_nettype wire

/* design/diff_drive_wheel_speed_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// diff_drive_wheel_speed_top
// Turns a body command (forward speed, turn rate) into left and right
// wheel speeds, scaled down together when either exceeds the limit.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : command requests (valid/ready), one result request per command
//   out_*  : wheel speed results (valid/ready), in command order
//   cfg_*  : register writes, always ready; write only while the block is idle
// Path: a command taken by in_ready loads the first of 4 arithmetic stages,
//   then passes through 15 divider stages and the output register before
//   out_valid rises.
// Throughput: one command per cycle unless a stall holds the pipeline. Each
//   divider stage resolves one quotient bit, so the 15-bit quotient sets the pipeline depth.
// Stall: when the receiver holds out_ready low, one more result lands in a
//   skid register; in_ready then drops and the whole pipeline holds until
//   the skid register drains. Nothing is dropped or repeated.
// Reset: clears all valid bits and loads the register reset values
//   (half wheelbase 75 mm, speed limit 1000 mm/s, straight threshold 87).
// ----------------------------------------------------------------------------
module diff_drive_wheel_speed_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire dws_pkg::cmd_t                     in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output dws_pkg::wheel_t                        out_data,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [dws_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [dws_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import dws_pkg::*;

  localparam int NPIPE    = 4 + QUO_BITS;
  localparam int CMP_BITS = (SPEED_BITS > THR_BITS) ? SPEED_BITS : THR_BITS;
  localparam int LCW      = (MAG_BITS > LIMS_BITS) ? MAG_BITS : LIMS_BITS;

  typedef struct packed {
    logic sign_l;
    logic sign_r;
    logic limited;
  } side_t;

  // configuration
  logic [HW_BITS-1:0]   half_wheelbase;
  logic [LIM_BITS-1:0]  speed_limit;
  logic [THR_BITS-1:0]  straight_thr;
  logic [LIMS_BITS-1:0] lim_scaled;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_wheelbase <= HALF_WHEELBASE_RST;
      speed_limit    <= SPEED_LIMIT_RST;
      straight_thr   <= STRAIGHT_THR_RST;
      lim_scaled     <= LIMS_BITS'(SPEED_LIMIT_RST) * LIMS_BITS'(SCALE);
    end else begin
      lim_scaled <= LIMS_BITS'(speed_limit) * LIMS_BITS'(SCALE);
      if (cfg_valid) begin
        case (cfg_index)
          REG_HALF_WHEELBASE: half_wheelbase <= cfg_data[HW_BITS-1:0];
          REG_SPEED_LIMIT:    speed_limit    <= cfg_data[LIM_BITS-1:0];
          REG_STRAIGHT_THR:   straight_thr   <= cfg_data[THR_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  // pipeline control
  logic             run;
  logic             skid_v;
  logic [NPIPE-1:0] vld;

  assign run      = !skid_v;
  assign in_ready = run;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (run) begin
      vld <= {vld[NPIPE-2:0], in_valid};
    end
  end

  // stage 0: wide left and right values
  logic signed [WIDE_BITS-1:0] base_c, turn_c;
  logic [SPEED_BITS-1:0]       rate_mag_c;
  logic                        straight_c;
  logic signed [WIDE_BITS-1:0] wl0, wr0;

  always_comb begin
    base_c = WIDE_BITS'(in_data.linear_speed) * $signed(WIDE_BITS'(SCALE));
    turn_c = WIDE_BITS'(in_data.angular_rate) * $signed({1'b0, half_wheelbase});
    rate_mag_c = in_data.angular_rate[SPEED_BITS-1] ?
                 SPEED_BITS'(-in_data.angular_rate) : SPEED_BITS'(in_data.angular_rate);
    straight_c = CMP_BITS'(rate_mag_c) < CMP_BITS'(straight_thr);
  end

  always_ff @(posedge clk) begin
    if (run) begin
      wl0 <= straight_c ? base_c : base_c - turn_c;
      wr0 <= straight_c ? base_c : base_c + turn_c;
    end
  end

  // stage 1: magnitudes and signs
  logic [MAG_BITS-1:0] ml1, mr1;
  logic                sl1, sr1;

  always_ff @(posedge clk) begin
    if (run) begin
      ml1 <= wl0[WIDE_BITS-1] ? MAG_BITS'(-wl0) : MAG_BITS'(wl0);
      mr1 <= wr0[WIDE_BITS-1] ? MAG_BITS'(-wr0) : MAG_BITS'(wr0);
      sl1 <= wl0[WIDE_BITS-1];
      sr1 <= wr0[WIDE_BITS-1];
    end
  end

  // stage 2: larger magnitude and limit check
  logic [MAG_BITS-1:0] ml2, mr2, m2;
  logic                sl2, sr2, lim2;

  always_ff @(posedge clk) begin
    if (run) begin
      ml2  <= ml1;
      mr2  <= mr1;
      m2   <= (ml1 > mr1) ? ml1 : mr1;
      sl2  <= sl1;
      sr2  <= sr1;
      lim2 <= (LCW'(ml1) > LCW'(lim_scaled)) || (LCW'(mr1) > LCW'(lim_scaled));
    end
  end

  // stage 3: dividends and shared divisor
  logic [NUM_BITS-1:0] numl3, numr3;
  logic [MAG_BITS-1:0] den3;
  side_t               side3;

  always_ff @(posedge clk) begin
    if (run) begin
      numl3 <= lim2 ? NUM_BITS'(ml2) * NUM_BITS'(speed_limit) : NUM_BITS'(ml2);
      numr3 <= lim2 ? NUM_BITS'(mr2) * NUM_BITS'(speed_limit) : NUM_BITS'(mr2);
      den3  <= lim2 ? m2 : MAG_BITS'(SCALE);
      side3 <= '{sign_l: sl2, sign_r: sr2, limited: lim2};
    end
  end

  // divider stages
  logic [QUO_BITS-1:0] quo_l, quo_r;
  side_t               side [QUO_BITS];

  dws_div u_div_l (
    .clk (clk),
    .run (run),
    .num (numl3),
    .den (den3),
    .quo (quo_l)
  );

  dws_div u_div_r (
    .clk (clk),
    .run (run),
    .num (numr3),
    .den (den3),
    .quo (quo_r)
  );

  always_ff @(posedge clk) begin
    if (run) begin
      side[0] <= side3;
      for (int k = 1; k < QUO_BITS; k++) begin
        side[k] <= side[k-1];
      end
    end
  end

  // restore signs, truncation toward zero comes from dividing magnitudes
  logic [SPEED_BITS-1:0] ql_s, qr_s;
  wheel_t                res_c;
  side_t                 side_o;

  always_comb begin
    side_o              = side[QUO_BITS-1];
    ql_s                = SPEED_BITS'(quo_l);
    qr_s                = SPEED_BITS'(quo_r);
    res_c.left_speed    = side_o.sign_l ? -ql_s : ql_s;
    res_c.right_speed   = side_o.sign_r ? -qr_s : qr_s;
    res_c.speed_limited = side_o.limited;
  end

  // output register with one skid entry
  logic   p_v;
  wheel_t skid_data;

  assign p_v = vld[NPIPE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (run) begin
      if (!out_valid || out_ready) begin
        out_valid <= p_v;
      end else begin
        skid_v <= p_v;
      end
    end else if (out_ready) begin
      skid_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      if (!out_valid || out_ready) begin
        out_data <= res_c;
      end else begin
        skid_data <= res_c;
      end
    end else if (out_ready) begin
      out_data <= skid_data;
    end
  end

endmodule
`default_nettype wire

/* design/dws_chk.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dws_chk
// Port level checks of the wheel speed block: request hold under stall,
// skid behavior behind in_ready, request accounting and idle config writes.
// ----------------------------------------------------------------------------
module dws_chk (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire dws_pkg::cmd_t                     in_data,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire dws_pkg::wheel_t                   out_data,
  input wire logic                              cfg_valid,
  input wire logic                              cfg_ready,
  input wire logic [dws_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input wire logic [dws_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import dws_pkg::*;

  // pipeline stages, output register and skid entry
  localparam int DEPTH    = QUO_BITS + 6;
  localparam int CNT_BITS = $clog2(DEPTH + 2);

  logic [CNT_BITS-1:0] pending;
  logic                take_in, take_out;

  assign take_in  = in_valid && in_ready;
  assign take_out = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      case ({take_in, take_out})
        2'b10:   pending <= pending + 1'b1;
        2'b01:   pending <= pending - 1'b1;
        default: pending <= pending;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("command request changed or dropped while stalled");

  a_ready_skid: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && $past(out_valid && !out_ready))
    else $error("input stalled without a blocked result");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != '0)
    else $error("result request without an accepted command");

  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready && pending == '0 && !$isunknown({cfg_index, cfg_data}))
    else $error("register write while commands are in flight");

endmodule

bind diff_drive_wheel_speed_top dws_chk u_dws_chk (.*);
`default_nettype wire

/* tb/tb_diff_drive_wheel_speed_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_diff_drive_wheel_speed_top
// Drives body commands into the wheel speed block under several register
// settings, predicts each left/right speed pair and limit flag in a scoreboard
// and compares every result in order, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_diff_drive_wheel_speed_top;
  import dws_pkg::*;

  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;
  localparam int IDLE_PCT   = 7;
  localparam int SETTLE_CYC = 30;

  class wheel_scoreboard;
    logic [HW_BITS-1:0]  hw;
    logic [LIM_BITS-1:0] lim;
    logic [THR_BITS-1:0] thr;
    wheel_t              speeds_q[$];
    int                  errors;
    int                  n_cmds;
    int                  n_limited;

    function new();
      hw        = HALF_WHEELBASE_RST;
      lim       = SPEED_LIMIT_RST;
      thr       = STRAIGHT_THR_RST;
      errors    = 0;
      n_cmds    = 0;
      n_limited = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] d);
      case (idx)
        REG_HALF_WHEELBASE: hw  = d[HW_BITS-1:0];
        REG_SPEED_LIMIT:    lim = d[LIM_BITS-1:0];
        REG_STRAIGHT_THR:   thr = d[THR_BITS-1:0];
        default: ;
      endcase
    endfunction

    function wheel_t wheel_speeds(cmd_t c);
      longint lin, rate, base, d, wl, wr, ml, mr, m, lim_l, left, right;
      wheel_t r;
      lin   = longint'($signed(c.linear_speed));
      rate  = longint'($signed(c.angular_rate));
      lim_l = longint'(lim);
      base  = lin * 1000;
      wl    = base;
      wr    = base;
      // turning form unless the rate is inside the straight band
      if ((rate < 0 ? -rate : rate) >= longint'(thr)) begin
        d  = longint'(hw) * rate;
        wl = base - d;
        wr = base + d;
      end
      ml = wl < 0 ? -wl : wl;
      mr = wr < 0 ? -wr : wr;
      m  = ml > mr ? ml : mr;
      r.speed_limited = 1'b0;
      if (m > lim_l * 1000) begin
        // common scale keeps the left/right ratio
        left            = (wl * lim_l) / m;
        right           = (wr * lim_l) / m;
        r.speed_limited = 1'b1;
      end else begin
        left  = wl / 1000;
        right = wr / 1000;
      end
      r.left_speed  = left[SPEED_BITS-1:0];
      r.right_speed = right[SPEED_BITS-1:0];
      return r;
    endfunction

    function void note_cmd(cmd_t c);
      wheel_t w;
      w = wheel_speeds(c);
      n_cmds++;
      if (w.speed_limited) n_limited++;
      speeds_q.push_back(w);
    endfunction

    function void check_result(wheel_t got);
      wheel_t want;
      if (speeds_q.size() == 0) begin
        $error("unexpected result: left %0d right %0d limited %0b",
               got.left_speed, got.right_speed, got.speed_limited);
        errors++;
        return;
      end
      want = speeds_q.pop_front();
      if (got.left_speed !== want.left_speed) begin
        $error("left_speed expected %0d actual %0d", want.left_speed, got.left_speed);
        errors++;
      end
      if (got.right_speed !== want.right_speed) begin
        $error("right_speed expected %0d actual %0d", want.right_speed, got.right_speed);
        errors++;
      end
      if (got.speed_limited !== want.speed_limited) begin
        $error("speed_limited expected %0b actual %0b", want.speed_limited,
               got.speed_limited);
        errors++;
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  cmd_t                     in_data;
  logic                     out_valid;
  logic                     out_ready;
  wheel_t                   out_data;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  logic                     quiet;
  int                       n_settings;

  wheel_scoreboard sb = new();

  diff_drive_wheel_speed_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // accepted requests go to the scoreboard
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) sb.note_cmd(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  // receiver stalls
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = quiet ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    end
  end

  function automatic cmd_t mk_cmd(int lin, int rate);
    cmd_t c;
    c.linear_speed = lin[SPEED_BITS-1:0];
    c.angular_rate = rate[SPEED_BITS-1:0];
    return c;
  endfunction

  function automatic int edge_value();
    case ($urandom_range(6))
      0: return -32768;
      1: return -32767;
      2: return -1;
      3: return 0;
      4: return 1;
      5: return 32767;
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  function automatic cmd_t rand_cmd();
    int   pick;
    int   rate;
    cmd_t c;
    pick = $urandom_range(99);
    if (pick < 40) begin
      c.linear_speed = SPEED_BITS'($urandom);
      c.angular_rate = SPEED_BITS'($urandom);
    end else if (pick < 60) begin
      // rates around the straight band edge
      rate = int'(sb.thr) + int'($urandom_range(6)) - 3;
      if ($urandom_range(1)) rate = -rate;
      c = mk_cmd(int'($urandom_range(4000)) - 2000, rate);
    end else if (pick < 80) begin
      c = mk_cmd(int'($urandom_range(6000)) - 3000, int'($urandom_range(6000)) - 3000);
    end else begin
      c = mk_cmd(edge_value(), edge_value());
    end
    return c;
  endfunction

  task automatic send_cmd(cmd_t c);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, int d);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = d[CFG_DATA_BITS-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.speeds_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic run_setting(int hw, int lim, int thr, bit no_idle, int n);
    wait_drained();
    write_reg(REG_HALF_WHEELBASE, hw);
    write_reg(REG_SPEED_LIMIT, lim);
    write_reg(REG_STRAIGHT_THR, thr);
    n_settings++;
    quiet = no_idle;
    send_cmd(mk_cmd(0, 0));
    send_cmd(mk_cmd(32767, -32768));
    send_cmd(mk_cmd(-32768, 32767));
    for (int i = 0; i < n; i++) send_cmd(rand_cmd());
    quiet = 1'b0;
  endtask

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    quiet      = 1'b0;
    n_settings = 1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    repeat (3) @(negedge clk);

    // reset settings: band edges, limit edges, full scale corners
    send_cmd(mk_cmd(0, 0));
    send_cmd(mk_cmd(32767, 0));
    send_cmd(mk_cmd(-32768, 0));
    send_cmd(mk_cmd(0, 86));
    send_cmd(mk_cmd(0, 87));
    send_cmd(mk_cmd(0, -86));
    send_cmd(mk_cmd(0, -87));
    send_cmd(mk_cmd(0, 32767));
    send_cmd(mk_cmd(0, -32768));
    send_cmd(mk_cmd(32767, 32767));
    send_cmd(mk_cmd(-32768, -32768));
    send_cmd(mk_cmd(32767, -32768));
    send_cmd(mk_cmd(-32768, 32767));
    send_cmd(mk_cmd(1000, 0));
    send_cmd(mk_cmd(1001, 0));
    send_cmd(mk_cmd(-1000, 0));
    send_cmd(mk_cmd(-1001, 0));
    send_cmd(mk_cmd(500, 100));
    send_cmd(mk_cmd(-500, -100));
    send_cmd(mk_cmd(1, 87));
    send_cmd(mk_cmd(-1, -1));
    for (int i = 0; i < 180; i++) send_cmd(rand_cmd());

    run_setting(1023, 32767, 0, 1'b1, 200);   // widest base, highest limit, no straight band
    run_setting(0, 0, 4095, 1'b0, 200);       // zero limit scales everything to zero
    run_setting(32767, 1, 1, 1'b0, 200);      // upper data bits beyond the register drop

    // out of range index must leave the settings alone
    wait_drained();
    write_reg(REG_UNUSED, 32767);
    run_setting(75, 0, 0, 1'b0, 200);

    for (int p = 0; p < 3; p++) begin
      run_setting($urandom_range(1023), $urandom_range(32767), $urandom_range(4095),
                  1'b0, 200);
    end

    wait_drained();
    if (sb.speeds_q.size() != 0) begin
      $error("%0d results never arrived", sb.speeds_q.size());
      sb.errors++;
    end
    $display("covered %0d commands over %0d register settings, %0d of them speed limited",
             sb.n_cmds, n_settings, sb.n_limited);
    $display("mismatches found: %0d", sb.errors);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/dws_pkg.sv
design/dws_div.sv
design/diff_drive_wheel_speed_top.sv
design/dws_chk.sv
tb/tb_diff_drive_wheel_speed_top.sv
